// ===== src/psra_pkg.sv =====
// Shared constants for the palette slot run allocator.
// Slot status codes, command codes and reset values of a slot entry.
// No dependencies.
package psra_pkg;

  localparam int NUM_SLOTS_DEF   = 16;
  localparam int FIXED_SLOTS_DEF = 6;

  // ids below this limit always take a single slot
  localparam logic [15:0] SMALL_ID_LIMIT = 16'h0016;

  localparam logic [2:0] ST_EMPTY    = 3'd0;
  localparam logic [2:0] ST_RELEASED = 3'd1;
  localparam logic [2:0] ST_CONT     = 3'd2;
  localparam logic [2:0] ST_HEAD     = 3'd3;
  localparam logic [2:0] ST_RESERVED = 3'd4;

  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_REBIND  = 2'd2;
  localparam logic [1:0] CMD_RESET   = 2'd3;

  localparam logic [3:0]  RSV_RUN   = 4'd1;
  localparam logic [7:0]  RSV_REFS  = 8'h80;
  localparam logic [15:0] RSV_IDENT = 16'hffff;

endpackage

// ===== src/palette_slot_run_allocator_core.sv =====
// Palette slot run allocator: reference-counted runs in a slot table.
// One sequencer walks the slot table through a single read and write port.
// Depends on psra_pkg.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+-------------------------------------------
//   command  | start / busy                   | command, palette_id, run_length, slot_index
//   result   | strobe (one cycle, no stall)   | kind, slot, ok, move_from, move_to,
//            |                                | move_length, last
//   config   | cfg_valid / cfg_ready          | cfg_data (reserve top slot)
//
// An acquire of a fixed id goes straight to its result; a release or rebind reads its slot
// first. An acquire that compacts runs longest: each table scan walks the slots in turn,
// and each slot moved takes a copy step and a clear step, since the table has one read and one write port.
// Reset runs a clearing pass over every slot with busy high; a reset-table
// command runs the same pass. Results are never held off by the receiver.
module palette_slot_run_allocator_core #(
  parameter int NUM_SLOTS   = psra_pkg::NUM_SLOTS_DEF,
  parameter int FIXED_SLOTS = psra_pkg::FIXED_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [15:0] palette_id,
  input  logic [3:0]  run_length,
  input  logic [3:0]  slot_index,
  output logic        strobe,
  output logic        kind,
  output logic [3:0]  slot,
  output logic        ok,
  output logic [3:0]  move_from,
  output logic [3:0]  move_to,
  output logic [3:0]  move_length,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = SW + 1;
  localparam int JW = (CW > 4) ? CW : 4;

  localparam logic [CW-1:0] N_C   = CW'(NUM_SLOTS);
  localparam logic [CW-1:0] F_C   = CW'(FIXED_SLOTS);
  localparam logic [CW-1:0] F1_C  = CW'(FIXED_SLOTS + 1);
  localparam logic [CW-1:0] TOP_C = CW'(NUM_SLOTS - 1);

  localparam logic [3:0] S_RST   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_REF   = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_FIND  = 4'd5;
  localparam logic [3:0] S_ALLOC = 4'd6;
  localparam logic [3:0] S_CLR   = 4'd7;
  localparam logic [3:0] S_NXT   = 4'd8;
  localparam logic [3:0] S_FREE  = 4'd9;
  localparam logic [3:0] S_MCOPY = 4'd10;
  localparam logic [3:0] S_MCLR  = 4'd11;
  localparam logic [3:0] S_REL   = 4'd12;
  localparam logic [3:0] S_REB   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  // slot table
  logic [2:0]  mem_st [NUM_SLOTS];
  logic [3:0]  mem_rn [NUM_SLOTS];
  logic [7:0]  mem_rf [NUM_SLOTS];
  logic [15:0] mem_id [NUM_SLOTS];
  logic [2:0]  rd_st;
  logic [3:0]  rd_rn;
  logic [7:0]  rd_rf;
  logic [15:0] rd_id;

  logic          we;
  logic [SW-1:0] wa;
  logic [2:0]    w_st;
  logic [3:0]    w_rn;
  logic [7:0]    w_rf;
  logic [15:0]   w_id;
  logic [SW-1:0] ridx;

  logic [3:0]    state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [JW-1:0] j, j_next;
  logic [3:0]    c, c_next;
  logic          pass, pass_next;
  logic          compacted, compacted_next;
  logic          top_rsv, top_rsv_next;
  logic          emit_end, emit_end_next;
  logic          walk_rel, walk_rel_next;
  logic          rsv_top;
  logic [15:0]   pid_q, pid_q_next;
  logic [3:0]    len_q, len_q_next;
  logic [CW-1:0] base, base_next;
  logic [3:0]    kq, kq_next;
  logic [CW-1:0] cur, cur_next;
  logic [3:0]    curlen, curlen_next;
  logic [CW-1:0] dst, dst_next;
  logic [CW-1:0] res_slot, res_slot_next;
  logic          res_ok, res_ok_next;

  logic        strobe_next, kind_next, ok_next, last_next;
  logic [3:0]  slot_next, move_from_next, move_to_next, move_length_next;

  logic [JW-1:0] lim;
  logic          free_hit;
  logic [3:0]    acq_len;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign lim       = (kq == 4'd0) ? JW'(NUM_SLOTS) : JW'(kq);
  assign free_hit  = pass ? (rd_st <= psra_pkg::ST_RELEASED) : (rd_st == psra_pkg::ST_EMPTY);
  assign acq_len   = (palette_id < psra_pkg::SMALL_ID_LIMIT || run_length == 4'd0) ?
                     4'd1 : run_length;
  assign ridx      = (idx_next < N_C) ? idx_next[SW-1:0] : '0;

  always_comb begin
    state_next = state; idx_next = idx; j_next = j; c_next = c;
    pass_next = pass; compacted_next = compacted; top_rsv_next = top_rsv;
    emit_end_next = emit_end; walk_rel_next = walk_rel;
    pid_q_next = pid_q; len_q_next = len_q; base_next = base; kq_next = kq;
    cur_next = cur; curlen_next = curlen; dst_next = dst;
    res_slot_next = res_slot; res_ok_next = res_ok;
    strobe_next = 1'b0; kind_next = kind; slot_next = slot; ok_next = ok;
    last_next = last; move_from_next = move_from; move_to_next = move_to;
    move_length_next = move_length;
    we = 1'b0; wa = idx[SW-1:0];
    w_st = rd_st; w_rn = rd_rn; w_rf = rd_rf; w_id = rd_id;

    case (state)
      S_RST: begin
        we = 1'b1;
        if (idx < F_C || (top_rsv && idx == TOP_C)) begin
          w_st = psra_pkg::ST_RESERVED; w_rn = psra_pkg::RSV_RUN;
          w_rf = psra_pkg::RSV_REFS;    w_id = psra_pkg::RSV_IDENT;
        end else begin
          w_st = psra_pkg::ST_EMPTY; w_rn = '0; w_rf = '0; w_id = '0;
        end
        idx_next = idx + CW'(1);
        if (idx == TOP_C) begin
          state_next = emit_end ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          pid_q_next = palette_id;
          len_q_next = acq_len;
          res_slot_next = '0;
          res_ok_next = 1'b0;
          case (command)
            psra_pkg::CMD_ACQUIRE: begin
              if (palette_id < 16'(FIXED_SLOTS)) begin
                res_slot_next = CW'(palette_id[2:0]);
                res_ok_next = 1'b1;
                state_next = S_DONE;
              end else begin
                idx_next = F_C;
                state_next = S_LOOK;
              end
            end
            psra_pkg::CMD_RELEASE: begin
              idx_next = CW'(slot_index);
              state_next = (CW'(slot_index) < N_C) ? S_REL : S_DONE;
            end
            psra_pkg::CMD_REBIND: begin
              idx_next = CW'(slot_index);
              state_next = (CW'(slot_index) < N_C) ? S_REB : S_DONE;
            end
            default: begin
              top_rsv_next = rsv_top;
              emit_end_next = 1'b1;
              idx_next = '0;
              state_next = S_RST;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (idx == N_C) begin
          pass_next = 1'b0; c_next = '0; compacted_next = 1'b0;
          idx_next = F_C;
          state_next = S_FIND;
        end else if (rd_id == pid_q) begin
          base_next = idx;
          state_next = S_REF;
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      S_REF: begin
        res_slot_next = base;
        res_ok_next = 1'b1;
        if (rd_st == psra_pkg::ST_RESERVED) begin
          state_next = S_DONE;
        end else begin
          we = 1'b1;
          w_st = psra_pkg::ST_HEAD;
          w_rf = rd_rf + 8'd1;
          kq_next = rd_rn;
          j_next = JW'(1);
          walk_rel_next = 1'b0;
          idx_next = base + CW'(1);
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (j < lim && idx < N_C) begin
          we = 1'b1;
          if (walk_rel) begin
            w_st = psra_pkg::ST_RELEASED; w_rf = '0;
          end else begin
            w_st = psra_pkg::ST_CONT; w_rn = kq - j[3:0];
          end
          j_next = j + JW'(1);
          idx_next = idx + CW'(1);
        end else begin
          state_next = S_DONE;
        end
      end
      S_REL: begin
        state_next = S_DONE;
        if (rd_st == psra_pkg::ST_HEAD) begin
          if (rd_rf != 8'd1) begin
            we = 1'b1;
            w_rf = rd_rf - 8'd1;
          end else begin
            kq_next = rd_rn;
            j_next = '0;
            walk_rel_next = 1'b1;
            state_next = S_WALK;
          end
        end
      end
      S_REB: begin
        if (rd_st == psra_pkg::ST_HEAD) begin
          we = 1'b1;
          w_id = pid_q;
        end
        state_next = S_DONE;
      end
      S_FIND: begin
        if (idx == N_C) begin
          if (!pass) begin
            pass_next = 1'b1; c_next = '0; idx_next = F_C;
          end else if (!compacted) begin
            compacted_next = 1'b1;
            idx_next = '0;
            state_next = S_CLR;
          end else begin
            res_slot_next = '0; res_ok_next = 1'b0;
            state_next = S_DONE;
          end
        end else if (free_hit) begin
          if ({1'b0, c} + 5'd1 >= {1'b0, len_q}) begin
            base_next = idx - CW'(c);
            idx_next = idx - CW'(c);
            j_next = '0;
            state_next = S_ALLOC;
          end else begin
            c_next = c + 4'd1;
            idx_next = idx + CW'(1);
          end
        end else begin
          c_next = '0;
          idx_next = idx + CW'(1);
        end
      end
      S_ALLOC: begin
        if (j < JW'(len_q) && idx < N_C) begin
          we = 1'b1;
          if (j == '0) begin
            w_st = psra_pkg::ST_HEAD; w_rn = len_q; w_rf = 8'd1; w_id = pid_q;
          end else begin
            w_st = psra_pkg::ST_CONT; w_rn = len_q - j[3:0]; w_rf = '0; w_id = '0;
          end
          j_next = j + JW'(1);
          idx_next = idx + CW'(1);
        end else begin
          res_slot_next = base; res_ok_next = 1'b1;
          state_next = S_DONE;
        end
      end
      S_CLR: begin
        // drop released runs before compaction
        if (idx == N_C) begin
          idx_next = F1_C;
          state_next = S_NXT;
        end else begin
          if (rd_st <= psra_pkg::ST_RELEASED) begin
            we = 1'b1;
            w_st = psra_pkg::ST_EMPTY; w_rn = '0; w_rf = '0; w_id = '0;
          end
          idx_next = idx + CW'(1);
        end
      end
      S_NXT: begin
        if (idx == N_C) begin
          pass_next = 1'b0; c_next = '0; idx_next = F_C;
          state_next = S_FIND;
        end else if (rd_st inside {psra_pkg::ST_CONT, psra_pkg::ST_HEAD}) begin
          cur_next = idx;
          curlen_next = rd_rn;
          idx_next = F_C;
          state_next = S_FREE;
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      S_FREE: begin
        if (idx == N_C) begin
          pass_next = 1'b0; c_next = '0; idx_next = F_C;
          state_next = S_FIND;
        end else if (rd_st == psra_pkg::ST_EMPTY) begin
          if (cur > idx) begin
            strobe_next = 1'b1; kind_next = 1'b1; slot_next = '0; ok_next = 1'b0;
            last_next = 1'b0;
            move_from_next = 4'(cur); move_to_next = 4'(idx);
            move_length_next = curlen;
            dst_next = idx;
            j_next = '0;
            idx_next = cur;
            state_next = S_MCOPY;
          end else begin
            idx_next = cur + CW'(1);
            state_next = S_NXT;
          end
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      S_MCOPY: begin
        if (j < JW'(curlen) && idx < N_C && dst < N_C) begin
          we = 1'b1;
          wa = dst[SW-1:0];
          state_next = S_MCLR;
        end else begin
          idx_next = cur + CW'(1);
          state_next = S_NXT;
        end
      end
      S_MCLR: begin
        we = 1'b1;
        w_st = psra_pkg::ST_EMPTY; w_rn = '0; w_rf = '0; w_id = '0;
        idx_next = idx + CW'(1);
        dst_next = dst + CW'(1);
        j_next = j + JW'(1);
        state_next = S_MCOPY;
      end
      S_DONE: begin
        strobe_next = 1'b1; kind_next = 1'b0; slot_next = 4'(res_slot);
        ok_next = res_ok; last_next = 1'b1;
        move_from_next = '0; move_to_next = '0; move_length_next = '0;
        emit_end_next = 1'b0;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // table port: registered read with write-through for the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem_st[wa] <= w_st;
      mem_rn[wa] <= w_rn;
      mem_rf[wa] <= w_rf;
      mem_id[wa] <= w_id;
    end
    if (we && wa == ridx) begin
      rd_st <= w_st; rd_rn <= w_rn; rd_rf <= w_rf; rd_id <= w_id;
    end else begin
      rd_st <= mem_st[ridx]; rd_rn <= mem_rn[ridx];
      rd_rf <= mem_rf[ridx]; rd_id <= mem_id[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST;
      idx <= '0;
      top_rsv <= 1'b0;
      emit_end <= 1'b0;
      rsv_top <= 1'b0;
      strobe <= 1'b0;
      pass <= 1'b0;
      compacted <= 1'b0;
      walk_rel <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      top_rsv <= top_rsv_next;
      emit_end <= emit_end_next;
      strobe <= strobe_next;
      pass <= pass_next;
      compacted <= compacted_next;
      walk_rel <= walk_rel_next;
      if (cfg_valid && cfg_ready) begin
        rsv_top <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    j <= j_next; c <= c_next;
    pid_q <= pid_q_next; len_q <= len_q_next; base <= base_next; kq <= kq_next;
    cur <= cur_next; curlen <= curlen_next; dst <= dst_next;
    res_slot <= res_slot_next; res_ok <= res_ok_next;
    kind <= kind_next; slot <= slot_next; ok <= ok_next; last <= last_next;
    move_from <= move_from_next; move_to <= move_to_next;
    move_length <= move_length_next;
  end

`ifndef SYNTHESIS
  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !kind |-> last) else $error("final word without last");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("command accepted but block not busy");
  a_move_down: assert property (@(posedge clk) disable iff (rst)
    state == S_MCOPY |-> dst < idx) else $error("compaction move not downward");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("word emitted while idle");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for palette_slot_run_allocator_core.
// Keeps a shadow slot table, predicts every result word, drives commands and
// config writes. Depends on psra_pkg and the core.
`timescale 1ns / 1ps

module tb;

  localparam int NSLOT = psra_pkg::NUM_SLOTS_DEF;
  localparam int NFIX  = psra_pkg::FIXED_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] palette_id;
    logic [3:0]  run_length;
    logic [3:0]  slot_index;
  } cmd_word_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] slot;
    logic       ok;
    logic [3:0] move_from;
    logic [3:0] move_to;
    logic [3:0] move_length;
    logic       last;
  } res_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = psra_pkg::CMD_ACQUIRE;
  logic [15:0] palette_id = '0;
  logic [3:0]  run_length = '0;
  logic [3:0]  slot_index = '0;
  logic        strobe, kind, ok, last;
  logic [3:0]  slot, move_from, move_to, move_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  palette_slot_run_allocator_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .palette_id(palette_id), .run_length(run_length),
    .slot_index(slot_index), .strobe(strobe), .kind(kind), .slot(slot), .ok(ok),
    .move_from(move_from), .move_to(move_to), .move_length(move_length), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow slot table
  logic [2:0]  tbl_status [NSLOT];
  logic [3:0]  tbl_run    [NSLOT];
  logic [7:0]  tbl_refs   [NSLOT];
  logic [15:0] tbl_ident  [NSLOT];
  logic        top_reserve;

  cmd_word_t pending_cmds [$];
  res_word_t expected_res [$];
  int  errors = 0;
  int  cycles = 0;
  int  send_idle_pct = 14;
  bit  cmd_taken = 0;
  bit  cfg_seen = 0;

  function automatic res_word_t final_word(logic [3:0] s, logic good);
    res_word_t r;
    r = '0;
    r.slot = s;
    r.ok = good;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void clear_entry(int i);
    tbl_status[i] = psra_pkg::ST_EMPTY; tbl_run[i] = '0; tbl_refs[i] = '0;
    tbl_ident[i] = '0;
  endfunction

  function automatic void reserve_entry(int i);
    tbl_status[i] = psra_pkg::ST_RESERVED; tbl_run[i] = psra_pkg::RSV_RUN;
    tbl_refs[i] = psra_pkg::RSV_REFS; tbl_ident[i] = psra_pkg::RSV_IDENT;
  endfunction

  function automatic int find_id(logic [15:0] id);
    if (id < NFIX) return int'(id);
    for (int i = NFIX; i < NSLOT; i++)
      if (tbl_ident[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_run(int len);
    int c;
    c = 0;
    for (int i = NFIX; i < NSLOT; i++) begin
      if (tbl_status[i] == psra_pkg::ST_EMPTY) begin
        c++;
        if (c >= len) return i - (c - 1);
      end else c = 0;
    end
    c = 0;
    for (int i = NFIX; i < NSLOT; i++) begin
      if (tbl_status[i] <= psra_pkg::ST_RELEASED) begin
        c++;
        if (c >= len) return i - (c - 1);
      end else c = 0;
    end
    return -1;
  endfunction

  function automatic void take_ref(int s);
    int k, lim;
    if (tbl_status[s] == psra_pkg::ST_RESERVED) return;
    tbl_refs[s] = tbl_refs[s] + 8'd1;
    tbl_status[s] = psra_pkg::ST_HEAD;
    k = tbl_run[s];
    lim = (k == 0) ? NSLOT : k;
    for (int j = 1; j < lim && s + j < NSLOT; j++) begin
      tbl_run[s + j] = 4'(k - j);
      tbl_status[s + j] = psra_pkg::ST_CONT;
    end
  endfunction

  function automatic void drop_ref(int s);
    int k, lim;
    if (tbl_status[s] != psra_pkg::ST_HEAD) return;
    tbl_refs[s] = tbl_refs[s] - 8'd1;
    if (tbl_refs[s] != 0) return;
    k = tbl_run[s];
    lim = (k == 0) ? NSLOT : k;
    for (int j = 0; j < lim && s + j < NSLOT; j++) begin
      tbl_refs[s + j] = '0;
      tbl_status[s + j] = psra_pkg::ST_RELEASED;
    end
  endfunction

  function automatic int next_in_use(int from);
    for (int i = from; i < NSLOT; i++)
      if (tbl_status[i] == psra_pkg::ST_CONT || tbl_status[i] == psra_pkg::ST_HEAD)
        return i;
    return 0;
  endfunction

  // drop released runs, then slide used runs down; log each move if asked
  function automatic void compact_table(bit log_moves);
    int cur, f, len, a, b;
    res_word_t r;
    cur = NFIX;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_status[i] <= psra_pkg::ST_RELEASED) clear_entry(i);
    forever begin
      cur = next_in_use(cur + 1);
      if (cur == 0) break;
      f = find_run(1);
      if (f < 0) break;
      if (cur > f) begin
        len = tbl_run[cur];
        if (log_moves) begin
          r = '0;
          r.kind = 1'b1;
          r.move_from = 4'(cur);
          r.move_to = 4'(f);
          r.move_length = 4'(len);
          expected_res.push_back(r);
        end
        for (int j = 0; j < len && cur + j < NSLOT && f + j < NSLOT; j++) begin
          a = cur + j; b = f + j;
          tbl_status[b] = tbl_status[a]; tbl_run[b] = tbl_run[a];
          tbl_refs[b] = tbl_refs[a]; tbl_ident[b] = tbl_ident[a];
          clear_entry(a);
        end
      end
    end
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < NSLOT; i++) clear_entry(i);
    for (int i = 0; i < NFIX; i++) reserve_entry(i);
    if (top_reserve) begin
      compact_table(0);
      reserve_entry(NSLOT - 1);
    end
  endfunction

  function automatic void apply_command(cmd_word_t c);
    int s, len;
    case (c.command)
      psra_pkg::CMD_ACQUIRE: begin
        s = find_id(c.palette_id);
        if (s < 0) begin
          len = (c.palette_id < psra_pkg::SMALL_ID_LIMIT) ? 1 : int'(c.run_length);
          if (len == 0) len = 1;
          s = find_run(len);
          if (s < 0) begin
            compact_table(1);
            s = find_run(len);
          end
          if (s >= 0) begin
            tbl_ident[s] = c.palette_id; tbl_refs[s] = '0;
            tbl_run[s] = 4'(len); tbl_status[s] = psra_pkg::ST_HEAD;
            for (int j = 1; j < len && s + j < NSLOT; j++) begin
              tbl_ident[s + j] = '0; tbl_refs[s + j] = '0;
              tbl_run[s + j] = 4'(len - j); tbl_status[s + j] = psra_pkg::ST_CONT;
            end
          end
        end
        take_ref(s < 0 ? 0 : s);
        expected_res.push_back(final_word(s < 0 ? 4'd0 : 4'(s), s >= 0));
        return;
      end
      psra_pkg::CMD_RELEASE: drop_ref(c.slot_index);
      psra_pkg::CMD_REBIND:
        if (tbl_status[c.slot_index] == psra_pkg::ST_HEAD)
          tbl_ident[c.slot_index] = c.palette_id;
      default: wipe_table();
    endcase
    expected_res.push_back(final_word(4'd0, 1'b0));
  endfunction

  // mostly a live head, otherwise any slot
  function automatic logic [3:0] pick_slot();
    int heads [$];
    for (int i = 0; i < NSLOT; i++)
      if (tbl_status[i] == psra_pkg::ST_HEAD) heads.push_back(i);
    if (heads.size() > 0 && $urandom_range(99) < 75)
      return 4'(heads[$urandom_range(heads.size() - 1)]);
    return 4'($urandom_range(15));
  endfunction

  function automatic void queue_cmd(logic [1:0] op, logic [15:0] id, logic [3:0] len,
                                    logic [3:0] si);
    cmd_word_t c;
    c.command = op; c.palette_id = id; c.run_length = len; c.slot_index = si;
    pending_cmds.push_back(c);
  endfunction

  function automatic void queue_random(int n);
    logic [15:0] id;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        if ($urandom_range(9) == 0) id = 16'($urandom);
        else if ($urandom_range(9) == 0) id = 16'($urandom_range(21));
        else id = 16'h0100 + 16'($urandom_range(11));
        queue_cmd(psra_pkg::CMD_ACQUIRE, id,
                  4'($urandom_range(15) < 12 ? $urandom_range(1, 5) : $urandom_range(15)),
                  4'($urandom));
      end else if (r < 82) begin
        queue_cmd(psra_pkg::CMD_RELEASE, 16'($urandom), 4'($urandom), pick_slot());
      end else if (r < 95) begin
        queue_cmd(psra_pkg::CMD_REBIND, 16'h0100 + 16'($urandom_range(15)), 4'($urandom),
                  pick_slot());
      end else begin
        queue_cmd(psra_pkg::CMD_RESET, 16'($urandom), 4'($urandom), 4'($urandom));
      end
    end
  endfunction

  // monitor: predict on accepted commands, check result words
  always @(posedge clk) begin
    res_word_t got, want;
    if (!rst) begin
      cycles <= cycles + 1;
      if (cfg_valid && cfg_ready) begin
        top_reserve = cfg_data;
        cfg_seen = 1;
      end
      if (start && !busy) begin
        apply_command(pending_cmds[0]);
        cmd_taken = 1;
      end
      if (strobe) begin
        got = {kind, slot, ok, move_from, move_to, move_length, last};
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          errors++;
        end else begin
          want = expected_res.pop_front();
          if (got.kind != want.kind) begin
            $display("%0t: kind expected %h got %h", $time, want.kind, got.kind); errors++;
          end
          if (got.slot != want.slot) begin
            $display("%0t: slot expected %h got %h", $time, want.slot, got.slot); errors++;
          end
          if (got.ok != want.ok) begin
            $display("%0t: ok expected %h got %h", $time, want.ok, got.ok); errors++;
          end
          if (got.move_from != want.move_from) begin
            $display("%0t: move_from expected %h got %h", $time, want.move_from,
                     got.move_from);
            errors++;
          end
          if (got.move_to != want.move_to) begin
            $display("%0t: move_to expected %h got %h", $time, want.move_to, got.move_to);
            errors++;
          end
          if (got.move_length != want.move_length) begin
            $display("%0t: move_length expected %h got %h", $time, want.move_length,
                     got.move_length);
            errors++;
          end
          if (got.last != want.last) begin
            $display("%0t: last expected %h got %h", $time, want.last, got.last); errors++;
          end
        end
      end
    end
  end

  // driver: hold a presented word until taken, then maybe idle
  always @(negedge clk) begin
    bit hold;
    hold = start && !cmd_taken;
    if (cmd_taken) begin
      void'(pending_cmds.pop_front());
      cmd_taken = 0;
    end
    if (!hold) begin
      if (pending_cmds.size() == 0 || rst || $urandom_range(99) < send_idle_pct) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        command <= pending_cmds[0].command;
        palette_id <= pending_cmds[0].palette_id;
        run_length <= pending_cmds[0].run_length;
        slot_index <= pending_cmds[0].slot_index;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain();
    do @(posedge clk); while (pending_cmds.size() != 0 || expected_res.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reserve(logic v);
    @(negedge clk);
    cfg_seen = 0;
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_seen);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    top_reserve = 1'b0;
    wipe_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fixed ids, the reserved ident, small ids, zero length, wide fields
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'd0, 4'd0, 4'd0);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'd5, 4'd15, 4'd15);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'hffff, 4'd3, 4'd0);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0015, 4'd9, 4'd0);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0200, 4'd0, 4'd0);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0201, 4'd4, 4'd0);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0201, 4'd4, 4'd0);
    queue_cmd(psra_pkg::CMD_RELEASE, 16'h0, 4'd0, 4'd8);
    queue_cmd(psra_pkg::CMD_RELEASE, 16'h0, 4'd0, 4'd9);
    queue_cmd(psra_pkg::CMD_RELEASE, 16'hffff, 4'd15, 4'd0);
    queue_cmd(psra_pkg::CMD_REBIND, 16'h0300, 4'd0, 4'd7);
    queue_cmd(psra_pkg::CMD_REBIND, 16'h0301, 4'd0, 4'd10);
    queue_cmd(psra_pkg::CMD_RELEASE, 16'h0, 4'd0, 4'd6);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0015, 4'd0, 4'd0);
    // fill, free a middle run, then force compaction
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0400, 4'd3, 4'd0);
    queue_cmd(psra_pkg::CMD_RELEASE, 16'h0, 4'd0, 4'd7);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0401, 4'd2, 4'd0);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0402, 4'd15, 4'd0);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0403, 4'd5, 4'd0);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0300, 4'd1, 4'd0);
    queue_cmd(psra_pkg::CMD_RESET, 16'h0, 4'd0, 4'd0);
    drain();

    write_reserve(1'b1);
    queue_cmd(psra_pkg::CMD_RESET, 16'hffff, 4'd15, 4'd15);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'hffff, 4'd1, 4'd0);
    queue_cmd(psra_pkg::CMD_ACQUIRE, 16'h0500, 4'd10, 4'd0);
    queue_random(32);
    drain();

    write_reserve(1'b0);
    send_idle_pct = 56;
    queue_random(32);
    drain();

    write_reserve(1'b1);
    send_idle_pct = 0;
    queue_random(32);
    drain();

    if (errors == 0 && expected_res.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== palette_slot_run_allocator_core.f =====
src/psra_pkg.sv
src/palette_slot_run_allocator_core.sv
verif/tb.sv
